### sv/ipas_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and helpers of the image plane axis snap block
package ipas_pkg;

    localparam int VAL_W      = 32;
    localparam int MAG_W      = 33;
    localparam int HI_W       = MAG_W - 16;
    localparam int SUM_W      = 66;
    localparam int ROOT_W     = 33;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = ROOT_W + 4;
    localparam int SGN_W      = ROOT_W + 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] pos_x;
        logic signed [VAL_W-1:0] pos_y;
        logic signed [VAL_W-1:0] pos_z;
        logic signed [VAL_W-1:0] row_dir_x;
        logic signed [VAL_W-1:0] row_dir_y;
        logic signed [VAL_W-1:0] row_dir_z;
        logic signed [VAL_W-1:0] col_dir_x;
        logic signed [VAL_W-1:0] col_dir_y;
        logic signed [VAL_W-1:0] col_dir_z;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0] out_pos_x;
        logic signed [VAL_W-1:0] out_pos_y;
        logic signed [VAL_W-1:0] out_pos_z;
        logic signed [VAL_W-1:0] out_row_x;
        logic signed [VAL_W-1:0] out_row_y;
        logic signed [VAL_W-1:0] out_row_z;
        logic signed [VAL_W-1:0] out_col_x;
        logic signed [VAL_W-1:0] out_col_y;
        logic signed [VAL_W-1:0] out_col_z;
        logic                    axis_clash;
    } t_out;

    // per-item control that rides along with the datapath
    typedef struct packed {
        t_in        raw;
        logic       clash;
        logic [1:0] ra;
        logic [1:0] ca;
        logic [1:0] pa;
        logic       row_neg;
        logic       col_neg;
        logic       pos_neg;
    } t_side;

    // largest magnitude, ties x over y over z
    function automatic logic [1:0] major_axis(input logic [VAL_W-1:0] ax,
                                              input logic [VAL_W-1:0] ay,
                                              input logic [VAL_W-1:0] az);
        logic [1:0] res;
        if (ax >= ay) begin
            res = (ax >= az) ? AXIS_X : AXIS_Z;
        end else begin
            res = (ay >= az) ? AXIS_Y : AXIS_Z;
        end
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SGN_W:0] v);
        logic signed [VAL_W-1:0] res;
        if (v > $signed({{(SGN_W-VAL_W+2){1'b0}}, {(VAL_W-1){1'b1}}})) begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (v < $signed({{(SGN_W-VAL_W+2){1'b1}}, {(VAL_W-1){1'b0}}})) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = v[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

### sv/image_plane_axis_snap_top.sv
`timescale 1ns / 1ps
// image plane axis snap: top level with the full pipeline
//
// snaps one image plane (position, row and column directions, signed q16.16)
// onto the coordinate axes. one beat is accepted per cycle while o_ready is
// high, and every beat gives one result beat through the input register,
// then partial products, squares, sum of squares, 33 restoring square root
// stages and the output register.
// the latency is set by the square root, which retires one root bit per stage
// for all three vectors in parallel. the whole pipeline advances together and
// holds when the output register is full and not taken, so o_ready drops only
// while the result beat waits. when row and column share a major axis,
// axis_clash is set and the inputs come back unchanged. the origin registers
// (index 0..2) are written through the configuration channel, always ready;
// write them only while no beat is in flight. no clearing pass after reset.
module image_plane_axis_snap_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  ipas_pkg::t_in                         i_data,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output ipas_pkg::t_out                        o_data,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [ipas_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic signed [ipas_pkg::VAL_W-1:0]     i_cfg_data
);

    localparam int LAT   = 4 + ipas_pkg::SQRT_STEPS;
    localparam int VAL_W = ipas_pkg::VAL_W;
    localparam int MAG_W = ipas_pkg::MAG_W;
    localparam int HI_W  = ipas_pkg::HI_W;
    localparam int SUM_W = ipas_pkg::SUM_W;
    localparam int ROOT_W = ipas_pkg::ROOT_W;
    localparam int REM_W = ipas_pkg::REM_W;
    localparam int SGN_W = ipas_pkg::SGN_W;
    localparam int NS    = ipas_pkg::SQRT_STEPS;

    logic signed [VAL_W-1:0] r_org [3];

    logic                    r_vld  [LAT];
    ipas_pkg::t_side         r_side [LAT];

    logic [MAG_W-1:0]        r_mag [9];
    logic [2*HI_W-1:0]       r_hh  [9];
    logic [HI_W+15:0]        r_hl  [9];
    logic [31:0]             r_ll  [9];
    logic [SUM_W-1:0]        r_sq  [9];

    logic [SUM_W-1:0]        r_rad  [3][NS+1];
    logic [REM_W-1:0]        r_rem  [3][NS+1];
    logic [ROOT_W-1:0]       r_root [3][NS+1];

    logic                    r_out_vld;
    ipas_pkg::t_out          r_out;

    logic                    en;

    // configuration, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ipas_pkg::REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                ipas_pkg::REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                ipas_pkg::REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // whole pipe moves unless the output beat is stuck
    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // stage 0: relative position, magnitudes, major axes
    logic signed [VAL_W:0]   s0_rel [3];
    logic signed [VAL_W-1:0] s0_row [3];
    logic signed [VAL_W-1:0] s0_col [3];
    logic [MAG_W-1:0]        s0_mag [9];
    ipas_pkg::t_side         s0_side;

    always_comb begin
        s0_row[0] = i_data.row_dir_x;
        s0_row[1] = i_data.row_dir_y;
        s0_row[2] = i_data.row_dir_z;
        s0_col[0] = i_data.col_dir_x;
        s0_col[1] = i_data.col_dir_y;
        s0_col[2] = i_data.col_dir_z;
        s0_rel[0] = {i_data.pos_x[VAL_W-1], i_data.pos_x} - {r_org[0][VAL_W-1], r_org[0]};
        s0_rel[1] = {i_data.pos_y[VAL_W-1], i_data.pos_y} - {r_org[1][VAL_W-1], r_org[1]};
        s0_rel[2] = {i_data.pos_z[VAL_W-1], i_data.pos_z} - {r_org[2][VAL_W-1], r_org[2]};
        for (int k = 0; k < 3; k++) begin
            s0_mag[k]     = s0_rel[k][VAL_W] ? MAG_W'(-s0_rel[k]) : MAG_W'(s0_rel[k]);
            s0_mag[3 + k] = s0_row[k][VAL_W-1] ? {1'b0, VAL_W'(-s0_row[k])}
                                               : {1'b0, VAL_W'(s0_row[k])};
            s0_mag[6 + k] = s0_col[k][VAL_W-1] ? {1'b0, VAL_W'(-s0_col[k])}
                                               : {1'b0, VAL_W'(s0_col[k])};
        end
        s0_side.raw     = i_data;
        s0_side.ra      = ipas_pkg::major_axis(s0_mag[3][VAL_W-1:0], s0_mag[4][VAL_W-1:0],
                                               s0_mag[5][VAL_W-1:0]);
        s0_side.ca      = ipas_pkg::major_axis(s0_mag[6][VAL_W-1:0], s0_mag[7][VAL_W-1:0],
                                               s0_mag[8][VAL_W-1:0]);
        s0_side.clash   = (s0_side.ra == s0_side.ca);
        s0_side.pa      = 2'd3 - s0_side.ra - s0_side.ca;
        s0_side.row_neg = s0_row[s0_side.ra][VAL_W-1];
        s0_side.col_neg = s0_col[s0_side.ca][VAL_W-1];
        s0_side.pos_neg = s0_rel[s0_side.pa][VAL_W];
    end

    // valid and side info shift together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LAT; j++) r_vld[j] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_valid;
            for (int j = 1; j < LAT; j++) r_vld[j] <= r_vld[j-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= s0_side;
            for (int j = 1; j < LAT; j++) r_side[j] <= r_side[j-1];
        end
    end

    // input register, split squares, full squares, sum of squares
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_mag[k] <= s0_mag[k];
                r_hh[k]  <= r_mag[k][MAG_W-1:16] * r_mag[k][MAG_W-1:16];
                r_hl[k]  <= r_mag[k][MAG_W-1:16] * r_mag[k][15:0];
                r_ll[k]  <= r_mag[k][15:0] * r_mag[k][15:0];
                r_sq[k]  <= (SUM_W'(r_hh[k]) << 32) + (SUM_W'(r_hl[k]) << 17)
                            + SUM_W'(r_ll[k]);
            end
            for (int v = 0; v < 3; v++) begin
                r_rad[v][0]  <= r_sq[3*v] + r_sq[3*v + 1] + r_sq[3*v + 2];
                r_rem[v][0]  <= '0;
                r_root[v][0] <= '0;
            end
        end
    end

    // restoring square root, one root bit per stage
    for (genvar g = 0; g < NS; g++) begin : g_sqrt
        for (genvar v = 0; v < 3; v++) begin : g_vec
            logic [REM_W-1:0] rem_s;
            logic [REM_W-1:0] trial;
            logic             ge;

            always_comb begin
                rem_s = {r_rem[v][g][REM_W-3:0], r_rad[v][g][SUM_W-1 -: 2]};
                trial = {2'b00, r_root[v][g], 2'b01};
                ge    = (rem_s >= trial);
            end

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[v][g+1]  <= ge ? (rem_s - trial) : rem_s;
                    r_root[v][g+1] <= {r_root[v][g][ROOT_W-2:0], ge};
                    r_rad[v][g+1]  <= r_rad[v][g] << 2;
                end
            end
        end
    end

    // output stage: sign, origin, saturation, clash pass-through
    ipas_pkg::t_side         f_side;
    logic signed [SGN_W:0]   f_len  [3];
    logic signed [SGN_W:0]   f_org  [3];
    logic signed [VAL_W-1:0] f_pos  [3];
    logic signed [VAL_W-1:0] f_row  [3];
    logic signed [VAL_W-1:0] f_col  [3];
    ipas_pkg::t_out          n_out;

    always_comb begin
        f_side = r_side[LAT-1];
        f_len[0] = f_side.pos_neg ? -$signed({2'b00, r_root[0][NS]})
                                  :  $signed({2'b00, r_root[0][NS]});
        f_len[1] = f_side.row_neg ? -$signed({2'b00, r_root[1][NS]})
                                  :  $signed({2'b00, r_root[1][NS]});
        f_len[2] = f_side.col_neg ? -$signed({2'b00, r_root[2][NS]})
                                  :  $signed({2'b00, r_root[2][NS]});
        for (int k = 0; k < 3; k++) begin
            f_org[k] = {{(SGN_W+1-VAL_W){r_org[k][VAL_W-1]}}, r_org[k]};
            f_pos[k] = r_org[k];
            f_row[k] = '0;
            f_col[k] = '0;
        end
        f_pos[f_side.pa] = ipas_pkg::sat32(f_org[f_side.pa] + f_len[0]);
        f_row[f_side.ra] = ipas_pkg::sat32(f_len[1]);
        f_col[f_side.ca] = ipas_pkg::sat32(f_len[2]);

        if (f_side.clash) begin
            n_out.out_pos_x = f_side.raw.pos_x;
            n_out.out_pos_y = f_side.raw.pos_y;
            n_out.out_pos_z = f_side.raw.pos_z;
            n_out.out_row_x = f_side.raw.row_dir_x;
            n_out.out_row_y = f_side.raw.row_dir_y;
            n_out.out_row_z = f_side.raw.row_dir_z;
            n_out.out_col_x = f_side.raw.col_dir_x;
            n_out.out_col_y = f_side.raw.col_dir_y;
            n_out.out_col_z = f_side.raw.col_dir_z;
        end else begin
            n_out.out_pos_x = f_pos[0];
            n_out.out_pos_y = f_pos[1];
            n_out.out_pos_z = f_pos[2];
            n_out.out_row_x = f_row[0];
            n_out.out_row_y = f_row[1];
            n_out.out_row_z = f_row[2];
            n_out.out_col_x = f_col[0];
            n_out.out_col_y = f_col[1];
            n_out.out_col_z = f_col[2];
        end
        n_out.axis_clash = f_side.clash;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule
